// ----- rtl/core/ppsu_pkg.sv -----
package ppsu_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;
  localparam int XY_W             = 28;
  localparam int Z_W              = 24;
  localparam int PROD_W           = 45;
  localparam int CFG_IDX_W        = 2;

  localparam logic [11:0] LINEAR_GAIN_RESET  = 12'd384;
  localparam logic [11:0] ANGULAR_GAIN_RESET = 12'd1024;
  localparam logic signed [Z_W-1:0] HALF_PI_Q20 = 24'sd1647099;
  localparam logic signed [16:0] INV_GAIN_Q16   = 17'sd39797;

  localparam logic [1:0] OP_LEADER   = 2'd0;
  localparam logic [1:0] OP_FOLLOWER = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LINEAR_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_GAIN = 2'd1;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] heading;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        linear_speed;
    logic signed [15:0] angular_rate;
  } out_item_t;

  typedef struct packed {
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [15:0] heading;
  } tick_t;

  typedef struct packed {
    logic [11:0] linear_gain;
    logic [11:0] angular_gain;
  } gains_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // atan(2^-i) in Q.20, round to nearest
  function automatic logic [19:0] atan_q20(input logic [4:0] idx);
    logic [19:0] v;
    case (idx)
      5'd0:    v = 20'd823550;
      5'd1:    v = 20'd486170;
      5'd2:    v = 20'd256879;
      5'd3:    v = 20'd130396;
      5'd4:    v = 20'd65451;
      5'd5:    v = 20'd32757;
      5'd6:    v = 20'd16383;
      5'd7:    v = 20'd8192;
      5'd8:    v = 20'd4096;
      5'd9:    v = 20'd2048;
      5'd10:   v = 20'd1024;
      5'd11:   v = 20'd512;
      5'd12:   v = 20'd256;
      5'd13:   v = 20'd128;
      5'd14:   v = 20'd64;
      5'd15:   v = 20'd32;
      5'd16:   v = 20'd16;
      5'd17:   v = 20'd8;
      5'd18:   v = 20'd4;
      5'd19:   v = 20'd2;
      5'd20:   v = 20'd1;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/ppsu_front.sv -----
module ppsu_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  ppsu_pkg::in_item_t              in_data,
  output logic                            in_ready,
  input  logic                            cfg_valid,
  input  logic [ppsu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [11:0]                     cfg_data,
  output logic                            cfg_ready,
  input  ppsu_pkg::q_status_t             q_status,
  output logic                            q_push,
  output ppsu_pkg::tick_t                 q_wdata,
  output ppsu_pkg::gains_t                gains
);
  import ppsu_pkg::*;

  logic signed [15:0] leader_x_r, leader_y_r;
  logic signed [15:0] follower_x_r, follower_y_r, follower_heading_r;
  gains_t             gains_r;
  logic               in_xfer;

  assign in_ready  = !q_status.full;
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;
  assign gains     = gains_r;

  // snapshot the offset and heading at the tick; later updates do not touch it
  assign q_push          = in_xfer && (in_data.op == OP_TICK);
  assign q_wdata.dx      = 17'(leader_x_r) - 17'(follower_x_r);
  assign q_wdata.dy      = 17'(leader_y_r) - 17'(follower_y_r);
  assign q_wdata.heading = follower_heading_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leader_x_r         <= '0;
      leader_y_r         <= '0;
      follower_x_r       <= '0;
      follower_y_r       <= '0;
      follower_heading_r <= '0;
    end else if (in_xfer) begin
      if (in_data.op == OP_LEADER) begin
        leader_x_r <= in_data.pos_x;
        leader_y_r <= in_data.pos_y;
      end else if (in_data.op == OP_FOLLOWER) begin
        follower_x_r       <= in_data.pos_x;
        follower_y_r       <= in_data.pos_y;
        follower_heading_r <= in_data.heading;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.linear_gain  <= LINEAR_GAIN_RESET;
      gains_r.angular_gain <= ANGULAR_GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_LINEAR_GAIN) begin
        gains_r.linear_gain <= cfg_data;
      end else if (cfg_index == REG_ANGULAR_GAIN) begin
        gains_r.angular_gain <= cfg_data;
      end
    end
  end

endmodule

// ----- rtl/core/ppsu_queue.sv -----
module ppsu_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ppsu_pkg::tick_t     wdata,
  input  logic                pop,
  output ppsu_pkg::tick_t     rdata,
  output ppsu_pkg::q_status_t status
);
  import ppsu_pkg::*;

  tick_t      mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign status.full  = (cnt_r == 2'd2);
  assign status.empty = (cnt_r == 2'd0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rdata        = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/core/ppsu_back.sv -----
module ppsu_back #(
  parameter int CORDIC_STEPS = ppsu_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ppsu_pkg::q_status_t q_status,
  input  ppsu_pkg::tick_t     q_rdata,
  output logic                q_pop,
  input  ppsu_pkg::gains_t    gains,
  output logic                out_valid,
  output ppsu_pkg::out_item_t out_data,
  input  logic                out_ready
);
  import ppsu_pkg::*;

  localparam int EFF_STEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int ITER_W    = $clog2(EFF_STEPS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ITER = 3'd1;
  localparam logic [2:0] S_DIST = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]              state_r, state_nxt;
  logic [ITER_W-1:0]       cnt_r;
  logic signed [XY_W-1:0]  x_r, y_r;
  logic signed [Z_W-1:0]   z_r;
  logic                    zero_r;
  logic signed [15:0]      hdg_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [16:0]             dist_r;
  logic signed [17:0]      err_r;
  logic [28:0]             spd_prod_r;
  logic signed [30:0]      rate_prod_r;
  logic                    out_valid_r;
  out_item_t               out_data_r;

  logic signed [XY_W-1:0]  dx_w, dy_w, x_ld, y_ld, xs, ys;
  logic signed [Z_W-1:0]   z_ld, atan_w;
  logic signed [PROD_W-1:0] prod_rnd, dist_full;
  logic signed [Z_W-1:0]   z_rnd, z_sh;
  logic signed [16:0]      bear;
  logic [16:0]             dist_nxt;
  logic [28:0]             spd_rnd;
  logic [20:0]             spd_sh;
  logic signed [30:0]      rate_rnd, rate_sh;
  logic                    last_iter, out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign last_iter = (cnt_r == ITER_W'(EFF_STEPS - 1));
  assign q_pop     = (state_r == S_IDLE) && !q_status.empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // pre-rotate into the right half-plane
  always_comb begin
    dx_w = {{(XY_W-25){q_rdata.dx[16]}}, q_rdata.dx, 8'b0};
    dy_w = {{(XY_W-25){q_rdata.dy[16]}}, q_rdata.dy, 8'b0};
    if (dx_w < 0 && dy_w >= 0) begin
      x_ld = dy_w;
      y_ld = -dx_w;
      z_ld = HALF_PI_Q20;
    end else if (dx_w < 0) begin
      x_ld = -dy_w;
      y_ld = dx_w;
      z_ld = -HALF_PI_Q20;
    end else begin
      x_ld = dx_w;
      y_ld = dy_w;
      z_ld = '0;
    end
  end

  assign xs     = x_r >>> cnt_r;
  assign ys     = y_r >>> cnt_r;
  assign atan_w = $signed({{(Z_W-20){1'b0}}, atan_q20(5'(cnt_r))});

  assign prod_rnd  = prod_r + PROD_W'(64'sd8388608);
  assign dist_full = prod_rnd >>> 24;
  assign dist_nxt  = (zero_r || dist_full < 0) ? 17'd0 : dist_full[16:0];
  assign z_rnd     = z_r + Z_W'(64);
  assign z_sh      = z_rnd >>> 7;
  assign bear      = zero_r ? 17'sd0 : z_sh[16:0];

  assign spd_rnd  = spd_prod_r + 29'd128;
  assign spd_sh   = spd_rnd[28:8];
  assign rate_rnd = rate_prod_r + 31'sd1024;
  assign rate_sh  = rate_rnd >>> 11;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (!q_status.empty) state_nxt = S_ITER;
      S_ITER: if (last_iter) state_nxt = S_DIST;
      S_DIST: state_nxt = S_RND;
      S_RND:  state_nxt = S_MUL;
      S_MUL:  state_nxt = S_FIN;
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_ITER) begin
        cnt_r <= last_iter ? '0 : cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        x_r    <= x_ld;
        y_r    <= y_ld;
        z_r    <= z_ld;
        zero_r <= (q_rdata.dx == 17'sd0) && (q_rdata.dy == 17'sd0);
        hdg_r  <= q_rdata.heading;
      end
      S_ITER: begin
        if (y_r >= 0) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + atan_w;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - atan_w;
        end
      end
      S_DIST: prod_r <= PROD_W'(x_r) * PROD_W'(INV_GAIN_Q16);
      S_RND: begin
        dist_r <= dist_nxt;
        err_r  <= 18'(bear) - 18'(hdg_r);
      end
      S_MUL: begin
        spd_prod_r  <= 29'(dist_r) * 29'(gains.linear_gain);
        rate_prod_r <= 31'(err_r) * 31'($signed({1'b0, gains.angular_gain}));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      out_data_r.linear_speed <= (|spd_sh[20:16]) ? 16'hFFFF : spd_sh[15:0];
      if (rate_sh > 31'sd32767) begin
        out_data_r.angular_rate <= 16'sh7FFF;
      end else if (rate_sh < -31'sd32768) begin
        out_data_r.angular_rate <= 16'sh8000;
      end else begin
        out_data_r.angular_rate <= rate_sh[15:0];
      end
    end
  end

endmodule

// ----- rtl/core/pursuit_proportional_steering_unit.sv -----
// Proportional pursuit steering: op 0 stores the leader position, op 1 the
// follower position and heading, and op 2 (a tick) produces one result with
// linear_speed = linear_gain * distance and angular_rate = angular_gain *
// (bearing - heading), both saturated, the angle error left unwrapped. Updates
// are taken one per cycle while in_ready is high; a tick snapshots the offset into
// a two-entry queue and the back end works it off in steps (one load, one CORDIC
// rotation per step through a single shift-add unit, then distance multiply,
// rounding, gain multiply and saturation). in_ready drops only while two ticks
// are waiting. Gain writes are taken in any cycle on the cfg port.
module pursuit_proportional_steering_unit #(
  parameter int CORDIC_STEPS = ppsu_pkg::CORDIC_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  ppsu_pkg::in_item_t             in_data,
  output logic                           in_ready,
  output logic                           out_valid,
  output ppsu_pkg::out_item_t            out_data,
  input  logic                           out_ready,
  input  logic                           cfg_valid,
  input  logic [ppsu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [11:0]                    cfg_data,
  output logic                           cfg_ready
);
  import ppsu_pkg::*;

  q_status_t q_status;
  logic      q_push, q_pop;
  tick_t     q_wdata, q_rdata;
  gains_t    gains;

  ppsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_wdata   (q_wdata),
    .gains     (gains)
  );

  ppsu_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  ppsu_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .gains     (gains),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_ready (out_ready)
  );

endmodule

// ----- rtl/core/ppsu_checker.sv -----
module ppsu_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                cfg_ready
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready with empty queue after reset");

  a_cfg_rdy: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port stalled");

endmodule

bind pursuit_proportional_steering_unit ppsu_checker u_ppsu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .cfg_ready (cfg_ready)
);
